@@ hw/rtl/depth_pixel_backprojection_defines.svh @@
// Assertion macros shared by the depth back-projection RTL.
// Expects clk and rst_n in the scope where a macro is used.
`ifndef DEPTH_PIXEL_BACKPROJECTION_DEFINES_SVH
`define DEPTH_PIXEL_BACKPROJECTION_DEFINES_SVH

// Consequent holds in the same cycle as the antecedent.
`define DPB_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define DPB_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/dpb_pkg.sv @@
// Package for the depth back-projection block: widths, reset values,
// register indexes and the controller/datapath command and status types.
// No dependencies.
package dpb_pkg;

    localparam int COORD_BITS_DEF = 12;
    localparam int FRAC_BITS_DEF  = 8;

    localparam int DEPTH_W    = 16;
    localparam int POS_W      = 32;
    localparam int WIDTH_W    = 13;
    localparam int STEP_W     = 5;
    localparam int PHASE_W    = 4;
    localparam int RECIP_W    = 24;
    localparam int CENTER_W   = 20;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 24;

    localparam logic [WIDTH_W-1:0]  WIDTH_RST  = 13'd640;
    localparam logic [STEP_W-1:0]   STEP_RST   = 5'd1;
    localparam logic [STEP_W-1:0]   STEP_MAX   = 5'd16;
    localparam logic [DEPTH_W-1:0]  MAXD_RST   = 16'd10000;
    localparam logic [RECIP_W-1:0]  RECIP_RST  = 24'd27962;
    localparam logic [CENTER_W-1:0] CX_RST     = 20'd81920;
    localparam logic [CENTER_W-1:0] CY_RST     = 20'd61440;

    localparam logic [POS_W-1:0] POS_MAX = 32'h7FFF_FFFF;
    localparam logic [POS_W-1:0] POS_MIN = 32'h8000_0000;

    localparam logic [CFG_ADDR_W-1:0] REG_IMAGE_WIDTH   = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_DOWNSAMPLE    = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_MAX_DEPTH     = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_FOCAL_X_RECIP = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_FOCAL_Y_RECIP = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_CENTER_X      = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] REG_CENTER_Y      = 3'd6;

    typedef struct packed {
        logic accept;
        logic mul1_en;
        logic mul2_en;
        logic sum_en;
        logic out_load;
    } dpb_cmd_t;

    typedef struct packed {
        logic keep;
    } dpb_sts_t;

endpackage

@@ hw/rtl/dpb_ctrl.sv @@
// Controller for the depth back-projection block: sequences one item
// through the multiply/sum steps and owns the input and output handshakes.
// Depends on dpb_pkg and depth_pixel_backprojection_defines.svh.
`include "depth_pixel_backprojection_defines.svh"

module dpb_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    input  dpb_pkg::dpb_sts_t sts,
    output dpb_pkg::dpb_cmd_t cmd
);

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_MUL1 = 5'b00010,
        ST_MUL2 = 5'b00100,
        ST_SUM  = 5'b01000,
        ST_DONE = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_free  = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next   = state_reg;
        cmd          = '0;
        cmd.accept   = in_valid && in_ready;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && sts.keep)
                begin
                    state_next = ST_MUL1;
                end
            end
            ST_MUL1:
            begin
                cmd.mul1_en = 1'b1;
                state_next  = ST_MUL2;
            end
            ST_MUL2:
            begin
                cmd.mul2_en = 1'b1;
                state_next  = ST_SUM;
            end
            ST_SUM:
            begin
                cmd.sum_en = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    `DPB_ASSERT_NEXT(a_keep_starts_work, in_valid && in_ready && sts.keep, state_reg == ST_MUL1, "kept item did not start the multiply sequence")
    `DPB_ASSERT_SAME(a_load_only_when_free, cmd.out_load, !out_valid_reg || out_ready, "output register overwritten while full")
    `DPB_ASSERT_SAME(a_no_accept_while_busy, cmd.mul1_en || cmd.mul2_en || cmd.sum_en || cmd.out_load, !in_ready, "item accepted while another is in flight")
    `DPB_ASSERT_NEXT(a_load_sets_valid, cmd.out_load, out_valid_reg, "loaded result not presented")

endmodule

@@ hw/rtl/dpb_datapath.sv @@
// Datapath for the depth back-projection block: configuration registers,
// column/row counters, two-step projection multiply, rounding and saturation.
// Depends on dpb_pkg.
module dpb_datapath #(
    parameter int COORD_BITS = dpb_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = dpb_pkg::FRAC_BITS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_wr_en,
    input  logic [dpb_pkg::CFG_ADDR_W-1:0]       cfg_addr,
    input  logic [dpb_pkg::CFG_DATA_W-1:0]       cfg_wdata,
    input  logic [dpb_pkg::DEPTH_W-1:0]          depth_mm,
    input  logic                                 frame_start,
    input  dpb_pkg::dpb_cmd_t                    cmd,
    output dpb_pkg::dpb_sts_t                    sts,
    output logic signed [dpb_pkg::POS_W-1:0]     x_pos,
    output logic signed [dpb_pkg::POS_W-1:0]     y_pos,
    output logic [dpb_pkg::DEPTH_W-1:0]          z_mm
);

    localparam int PW = COORD_BITS + FRAC_BITS;
    localparam int DW = (PW > dpb_pkg::CENTER_W) ? PW : dpb_pkg::CENTER_W;
    localparam int MW = DW + dpb_pkg::DEPTH_W;
    localparam int LW = dpb_pkg::RECIP_W;
    localparam int HW = MW - LW;
    localparam int PRW = 2 * LW;
    localparam int AW = MW + 1;
    localparam int EW = (COORD_BITS + 1 > dpb_pkg::WIDTH_W) ? COORD_BITS + 1 : dpb_pkg::WIDTH_W;
    localparam logic [EW-1:0]  WIDTH_LIM = EW'(1) << COORD_BITS;
    localparam logic [PRW-1:0] ROUND_HALF = PRW'(1) << (LW - 1);

    logic [dpb_pkg::WIDTH_W-1:0]  image_width_reg;
    logic [dpb_pkg::STEP_W-1:0]   step_reg;
    logic [dpb_pkg::DEPTH_W-1:0]  max_depth_reg;
    logic [dpb_pkg::RECIP_W-1:0]  recip_x_reg;
    logic [dpb_pkg::RECIP_W-1:0]  recip_y_reg;
    logic [dpb_pkg::CENTER_W-1:0] center_x_reg;
    logic [dpb_pkg::CENTER_W-1:0] center_y_reg;

    logic [COORD_BITS-1:0]       col_reg, col_next, col_cur;
    logic [COORD_BITS-1:0]       row_reg, row_next, row_cur, row_inc;
    logic [dpb_pkg::PHASE_W-1:0] cph_reg, cph_next, cph_cur;
    logic [dpb_pkg::PHASE_W-1:0] rph_reg, rph_next, rph_cur;
    logic [dpb_pkg::STEP_W-1:0]  step_eff, cph_inc, rph_inc;
    logic [EW-1:0]               width_eff, col_inc;
    logic                        col_last;

    logic [DW-1:0] pos_x, pos_y, cen_x, cen_y;
    logic [DW-1:0] dx_next, dy_next;
    logic          negx_next, negy_next;

    logic [DW-1:0]               dx_reg, dy_reg;
    logic                        negx_reg, negy_reg;
    logic [dpb_pkg::DEPTH_W-1:0] z_reg;
    logic [MW-1:0]               mx_reg, my_reg;
    logic [MW-1:0]               hx_reg, hy_reg;
    logic [PRW-1:0]              lx_reg, ly_reg;
    logic [PRW-1:0]              lx_rnd, ly_rnd;
    logic [AW-1:0]               magx_reg, magy_reg;
    logic [dpb_pkg::POS_W-1:0]   x_out_reg, y_out_reg;
    logic [dpb_pkg::DEPTH_W-1:0] z_out_reg;

    function automatic logic [dpb_pkg::POS_W-1:0] saturate(input logic [AW-1:0] mag,
                                                           input logic neg);
        logic [dpb_pkg::POS_W-1:0] res;
        if (neg)
        begin
            if (mag >= AW'(dpb_pkg::POS_MIN))
            begin
                res = dpb_pkg::POS_MIN;
            end
            else
            begin
                res = '0 - mag[dpb_pkg::POS_W-1:0];
            end
        end
        else if (mag > AW'(dpb_pkg::POS_MAX))
        begin
            res = dpb_pkg::POS_MAX;
        end
        else
        begin
            res = mag[dpb_pkg::POS_W-1:0];
        end
        return res;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg <= dpb_pkg::WIDTH_RST;
            step_reg        <= dpb_pkg::STEP_RST;
            max_depth_reg   <= dpb_pkg::MAXD_RST;
            recip_x_reg     <= dpb_pkg::RECIP_RST;
            recip_y_reg     <= dpb_pkg::RECIP_RST;
            center_x_reg    <= dpb_pkg::CX_RST;
            center_y_reg    <= dpb_pkg::CY_RST;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_addr)
                dpb_pkg::REG_IMAGE_WIDTH:   image_width_reg <= cfg_wdata[dpb_pkg::WIDTH_W-1:0];
                dpb_pkg::REG_DOWNSAMPLE:    step_reg        <= cfg_wdata[dpb_pkg::STEP_W-1:0];
                dpb_pkg::REG_MAX_DEPTH:     max_depth_reg   <= cfg_wdata[dpb_pkg::DEPTH_W-1:0];
                dpb_pkg::REG_FOCAL_X_RECIP: recip_x_reg     <= cfg_wdata[dpb_pkg::RECIP_W-1:0];
                dpb_pkg::REG_FOCAL_Y_RECIP: recip_y_reg     <= cfg_wdata[dpb_pkg::RECIP_W-1:0];
                dpb_pkg::REG_CENTER_X:      center_x_reg    <= cfg_wdata[dpb_pkg::CENTER_W-1:0];
                dpb_pkg::REG_CENTER_Y:      center_y_reg    <= cfg_wdata[dpb_pkg::CENTER_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // counters as seen by the current item, after a frame start clear
    always_comb
    begin
        col_cur = frame_start ? '0 : col_reg;
        row_cur = frame_start ? '0 : row_reg;
        cph_cur = frame_start ? '0 : cph_reg;
        rph_cur = frame_start ? '0 : rph_reg;

        sts.keep = (cph_cur == '0) && (rph_cur == '0) && (depth_mm != '0)
                   && (depth_mm <= max_depth_reg);

        if (image_width_reg == '0)
        begin
            width_eff = EW'(1);
        end
        else if (EW'(image_width_reg) > WIDTH_LIM)
        begin
            width_eff = WIDTH_LIM;
        end
        else
        begin
            width_eff = EW'(image_width_reg);
        end

        if (step_reg == '0)
        begin
            step_eff = dpb_pkg::STEP_W'(1);
        end
        else if (step_reg > dpb_pkg::STEP_MAX)
        begin
            step_eff = dpb_pkg::STEP_MAX;
        end
        else
        begin
            step_eff = step_reg;
        end

        col_inc  = EW'(col_cur) + EW'(1);
        col_last = (col_inc >= width_eff);
        row_inc  = row_cur + COORD_BITS'(1);
        cph_inc  = dpb_pkg::STEP_W'(cph_cur) + dpb_pkg::STEP_W'(1);
        rph_inc  = dpb_pkg::STEP_W'(rph_cur) + dpb_pkg::STEP_W'(1);

        if (col_last)
        begin
            col_next = '0;
            cph_next = '0;
            row_next = row_inc;
            if (row_inc == '0 || rph_inc >= step_eff)
            begin
                rph_next = '0;
            end
            else
            begin
                rph_next = rph_inc[dpb_pkg::PHASE_W-1:0];
            end
        end
        else
        begin
            col_next = col_inc[COORD_BITS-1:0];
            row_next = row_cur;
            rph_next = rph_cur;
            cph_next = (cph_inc >= step_eff) ? '0 : cph_inc[dpb_pkg::PHASE_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
            cph_reg <= '0;
            rph_reg <= '0;
        end
        else if (cmd.accept)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
            cph_reg <= cph_next;
            rph_reg <= rph_next;
        end
    end

    // offset from the principal point as sign and magnitude
    always_comb
    begin
        pos_x     = DW'({col_cur, {FRAC_BITS{1'b0}}});
        pos_y     = DW'({row_cur, {FRAC_BITS{1'b0}}});
        cen_x     = DW'(center_x_reg);
        cen_y     = DW'(center_y_reg);
        negx_next = cen_x > pos_x;
        negy_next = cen_y > pos_y;
        dx_next   = negx_next ? (cen_x - pos_x) : (pos_x - cen_x);
        dy_next   = negy_next ? (cen_y - pos_y) : (pos_y - cen_y);
        lx_rnd    = lx_reg + ROUND_HALF;
        ly_rnd    = ly_reg + ROUND_HALF;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            dx_reg   <= dx_next;
            dy_reg   <= dy_next;
            negx_reg <= negx_next;
            negy_reg <= negy_next;
            z_reg    <= depth_mm;
        end
        if (cmd.mul1_en)
        begin
            mx_reg <= MW'(dx_reg) * MW'(z_reg);
            my_reg <= MW'(dy_reg) * MW'(z_reg);
        end
        if (cmd.mul2_en)
        begin
            hx_reg <= MW'(mx_reg[MW-1:LW]) * MW'(recip_x_reg);
            hy_reg <= MW'(my_reg[MW-1:LW]) * MW'(recip_y_reg);
            lx_reg <= PRW'(mx_reg[LW-1:0]) * PRW'(recip_x_reg);
            ly_reg <= PRW'(my_reg[LW-1:0]) * PRW'(recip_y_reg);
        end
        if (cmd.sum_en)
        begin
            magx_reg <= AW'(hx_reg) + AW'(lx_rnd[PRW-1:LW]);
            magy_reg <= AW'(hy_reg) + AW'(ly_rnd[PRW-1:LW]);
        end
        if (cmd.out_load)
        begin
            x_out_reg <= saturate(magx_reg, negx_reg);
            y_out_reg <= saturate(magy_reg, negy_reg);
            z_out_reg <= z_reg;
        end
    end

    assign x_pos = signed'(x_out_reg);
    assign y_pos = signed'(y_out_reg);
    assign z_mm  = z_out_reg;

endmodule

@@ hw/rtl/depth_pixel_backprojection.sv @@
// Top level of the depth pixel back-projection block.
// Depends on dpb_pkg, dpb_ctrl and dpb_datapath.
//
//   channel | handshake              | payload
//   in      | in_valid / in_ready    | depth_mm, frame_start
//   out     | out_valid / out_ready  | x_pos, y_pos, z_mm
//   cfg     | cfg_wr_en              | cfg_addr, cfg_wdata
//
// A dropped pixel is accepted without leaving idle; a kept pixel passes from
// accept through the two chained multiply steps, the rounding sum and the
// output load before the next accept. One item is in flight at a time.
// Reset clears counters, control and configuration to defaults.
// A full output register stalls the load step until out_ready frees it.
module depth_pixel_backprojection #(
    parameter int COORD_BITS = dpb_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = dpb_pkg::FRAC_BITS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_wr_en,
    input  logic [dpb_pkg::CFG_ADDR_W-1:0]       cfg_addr,
    input  logic [dpb_pkg::CFG_DATA_W-1:0]       cfg_wdata,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [dpb_pkg::DEPTH_W-1:0]          depth_mm,
    input  logic                                 frame_start,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic signed [dpb_pkg::POS_W-1:0]     x_pos,
    output logic signed [dpb_pkg::POS_W-1:0]     y_pos,
    output logic [dpb_pkg::DEPTH_W-1:0]          z_mm
);

    dpb_pkg::dpb_cmd_t cmd;
    dpb_pkg::dpb_sts_t sts;

    dpb_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    dpb_datapath #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wdata   (cfg_wdata),
        .depth_mm    (depth_mm),
        .frame_start (frame_start),
        .cmd         (cmd),
        .sts         (sts),
        .x_pos       (x_pos),
        .y_pos       (y_pos),
        .z_mm        (z_mm)
    );

endmodule
